>>> rtl/dbp3_pkg.sv
// dbp3_pkg: shared constants, register indexes and helpers for the depth back-projection block
// no dependencies; used by rtl/depth_backprojection_flip3.sv
// field widths are fixed by the stream format, size limits are parameter defaults

package dbp3_pkg;

    // default frame size limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    // register widths
    localparam int INV_W    = 24;
    localparam int CENTER_W = 20;
    localparam int SIZE_W   = 13;

    // register reset values
    localparam logic [INV_W-1:0]    INV_FOCAL_X_RST  = 24'd23252;
    localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST  = 24'd23252;
    localparam logic [CENTER_W-1:0] CENTER_X_RST     = 20'd156047;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST     = 20'd38363;
    localparam logic [SIZE_W-1:0]   IMAGE_WIDTH_RST  = 13'd1242;
    localparam logic [SIZE_W-1:0]   IMAGE_HEIGHT_RST = 13'd375;

    // item fields
    localparam int DEPTH_W = 16;
    localparam int NORM_W  = 16;
    localparam int POINT_W = 32;
    localparam int VARIANT_W = 2;
    localparam int S_TDATA_W = DEPTH_W + 3 * NORM_W;
    localparam int M_TDATA_W = 2 * POINT_W + DEPTH_W + 3 * NORM_W;

    // fraction bits dropped after the depth product, and the rounding half
    localparam int FRAC_W = 24;
    localparam logic [FRAC_W+DEPTH_W:0] ROUND_HALF = 41'h800000;

    // output variants
    localparam logic [VARIANT_W-1:0] VARIANT_ORIG      = 2'd0;
    localparam logic [VARIANT_W-1:0] VARIANT_MIRROR_LR = 2'd1;
    localparam logic [VARIANT_W-1:0] VARIANT_MIRROR_UD = 2'd2;

    // saturation bounds
    localparam logic [POINT_W-1:0] POINT_MAX = 32'h7FFF_FFFF;
    localparam logic [POINT_W-1:0] POINT_MIN = 32'h8000_0000;

    // negate a Q1.15 value, the most negative code saturates
    function automatic logic [NORM_W-1:0] neg_norm(input logic [NORM_W-1:0] v);
        logic [NORM_W-1:0] r;
        if (v == {1'b1, {(NORM_W-1){1'b0}}}) begin
            r = {1'b0, {(NORM_W-1){1'b1}}};
        end else begin
            r = ~v + NORM_W'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/depth_backprojection_flip3.sv
// depth_backprojection_flip3: pinhole back-projection of depth pixels, with two mirrored copies
// depends on rtl/dbp3_pkg.sv
//
// usage
//   s_ channel: one pixel per item in raster order; s_tuser marks the first pixel of a
//   frame and clears the column and row counters before that pixel is used.
//   m_ channel: three points per pixel of nonzero depth, variant in m_tuser
//   (original, left-right mirror, up-down mirror); m_tlast flags the third point.
//   a zero-depth pixel only advances the counters and gives no item.
//   cfg_ port: write enable, register index, data; write only while idle.
// timing
//   every coordinate runs through one shared 24-bit multiplier in five steps
//   (setup, focal multiply, low depth multiply, high depth multiply with rounding of
//   the low part, sum and saturate), then an emit step loads the output register.
//   a zero-depth pixel leaves the sequencer idle. s_tready is low while a pixel is
//   being worked on.
//   a point waiting on m_tready stalls the sequencer before the next point is loaded,
//   while the following point is already computed behind the output register.
// reset
//   aresetn (synchronous, low) clears the counters, the sequencer and m_tvalid, and
//   loads the default camera registers.

module depth_backprojection_flip3 #(
    parameter int MAX_WIDTH  = dbp3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dbp3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [dbp3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dbp3_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: depth_mm, norm_x_in, norm_y_in, norm_z_in
    input  logic [dbp3_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: frame_start
    input  logic [0:0]                       s_tuser,
    // point output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: point_x, point_y, point_z, norm_x_out, norm_y_out, norm_z_out
    output logic [dbp3_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: variant
    output logic [dbp3_pkg::VARIANT_W-1:0]   m_tuser,
    output logic                             m_tlast
);

    localparam int DEPTH_W  = dbp3_pkg::DEPTH_W;
    localparam int NORM_W   = dbp3_pkg::NORM_W;
    localparam int POINT_W  = dbp3_pkg::POINT_W;
    localparam int INV_W    = dbp3_pkg::INV_W;
    localparam int CENTER_W = dbp3_pkg::CENTER_W;
    localparam int SIZE_W   = dbp3_pkg::SIZE_W;
    localparam int FRAC_W   = dbp3_pkg::FRAC_W;

    // counter and position widths
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int MAXP = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int PW   = $clog2(MAXP) + 1;
    localparam int SWW  = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
    localparam int SHW  = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ? $clog2(MAX_HEIGHT + 1) : SIZE_W;
    // Q.8 offset from the principal point, and its magnitude
    localparam int DW   = ((PW + 8 > CENTER_W + 1) ? PW + 8 : CENTER_W + 1) + 1;
    // shared multiplier operands and product
    localparam int AW   = (DW > INV_W) ? DW : INV_W;
    localparam int PRW  = AW + INV_W;
    localparam int LOW  = FRAC_W + DEPTH_W;
    localparam int RRW  = DW + DEPTH_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL_INV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [INV_W-1:0]    inv_fx_reg, inv_fy_reg;
    logic [CENTER_W-1:0] cx_reg, cy_reg;
    logic [SIZE_W-1:0]   width_reg, height_reg;

    // raster counters
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    // latched pixel
    logic [DEPTH_W-1:0]   depth_reg;
    logic [NORM_W-1:0]    nx_reg, ny_reg, nz_reg;
    logic signed [PW-1:0] col_pos_reg, row_pos_reg, col_mir_reg, row_mir_reg;

    // sequencer
    logic [dbp3_pkg::VARIANT_W-1:0] variant_reg;
    logic                           coord_y_reg;

    // datapath registers
    logic [DW-1:0]       mag_reg;
    logic                neg_reg;
    logic [PRW-1:0]      prod_reg;
    logic [DW-1:0]       hi_reg;
    logic [DEPTH_W:0]    frac_reg;
    logic [POINT_W-1:0]  x_res_reg, y_res_reg;

    // output registers
    logic                           m_valid_reg;
    logic [POINT_W-1:0]             out_x_reg, out_y_reg;
    logic [DEPTH_W-1:0]             out_z_reg;
    logic [NORM_W-1:0]              out_nx_reg, out_ny_reg, out_nz_reg;
    logic [dbp3_pkg::VARIANT_W-1:0] out_var_reg;
    logic                           out_last_reg;

    // effective frame size
    logic [SWW-1:0] w_eff;
    logic [SHW-1:0] h_eff;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = SWW'(1);
        end else if (SWW'(width_reg) > SWW'(MAX_WIDTH)) begin
            w_eff = SWW'(MAX_WIDTH);
        end else begin
            w_eff = SWW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = SHW'(1);
        end else if (SHW'(height_reg) > SHW'(MAX_HEIGHT)) begin
            h_eff = SHW'(MAX_HEIGHT);
        end else begin
            h_eff = SHW'(height_reg);
        end
    end

    // position of the incoming pixel and the counter advance
    logic                 in_accept;
    logic [CW-1:0]        cur_col;
    logic [RW-1:0]        cur_row;
    logic [RW:0]          row_inc;
    logic [CW-1:0]        col_next;
    logic [RW-1:0]        row_next;
    logic signed [PW-1:0] col_mir, row_mir;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        cur_col = s_tuser[0] ? '0 : col_reg;
        cur_row = s_tuser[0] ? '0 : row_reg;
        row_inc = (RW + 1)'(cur_row) + (RW + 1)'(1);
        if (SWW'(cur_col) + SWW'(1) >= w_eff) begin
            col_next = '0;
            if (row_inc == (RW + 1)'(MAX_HEIGHT)) begin
                row_next = '0;
            end else begin
                row_next = row_inc[RW-1:0];
            end
        end else begin
            col_next = cur_col + CW'(1);
            row_next = cur_row;
        end
        col_mir = $signed(PW'(w_eff) - PW'(1) - PW'(cur_col));
        row_mir = $signed(PW'(h_eff) - PW'(1) - PW'(cur_row));
    end

    // offset from the principal point for the current variant and coordinate
    logic signed [PW-1:0] pos_sel;
    logic [CENTER_W-1:0]  center_sel;
    logic [INV_W-1:0]     inv_sel;
    logic signed [DW-1:0] offset;

    always_comb begin
        if (coord_y_reg) begin
            pos_sel    = (variant_reg == dbp3_pkg::VARIANT_MIRROR_UD) ? row_mir_reg : row_pos_reg;
            center_sel = cy_reg;
            inv_sel    = inv_fy_reg;
        end else begin
            pos_sel    = (variant_reg == dbp3_pkg::VARIANT_MIRROR_LR) ? col_mir_reg : col_pos_reg;
            center_sel = cx_reg;
            inv_sel    = inv_fx_reg;
        end
        offset = (DW'(pos_sel) <<< 8) - $signed(DW'(center_sel));
    end

    // shared multiplier
    logic [AW-1:0]    mul_a;
    logic [INV_W-1:0] mul_b;
    logic [PRW-1:0]   mul_p;

    always_comb begin
        case (state_reg)
            ST_MUL_INV: begin
                mul_a = AW'(mag_reg);
                mul_b = inv_sel;
            end
            ST_MUL_LO: begin
                mul_a = AW'(prod_reg[FRAC_W-1:0]);
                mul_b = INV_W'(depth_reg);
            end
            ST_MUL_HI: begin
                mul_a = AW'(hi_reg);
                mul_b = INV_W'(depth_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PRW'(mul_a) * PRW'(mul_b);
    end

    // rounding of the low part, and final sum with saturation
    logic [LOW:0]       lo_round;
    logic [RRW-1:0]     mag_sum;
    logic [POINT_W-1:0] point_sat;

    always_comb begin
        lo_round = {1'b0, prod_reg[LOW-1:0]} + dbp3_pkg::ROUND_HALF;
        mag_sum  = RRW'(prod_reg[DW+DEPTH_W-1:0]) + RRW'(frac_reg);
        if (neg_reg) begin
            if (mag_sum > RRW'(dbp3_pkg::POINT_MIN)) begin
                point_sat = dbp3_pkg::POINT_MIN;
            end else begin
                point_sat = ~mag_sum[POINT_W-1:0] + POINT_W'(1);
            end
        end else begin
            if (mag_sum > RRW'(dbp3_pkg::POINT_MAX)) begin
                point_sat = dbp3_pkg::POINT_MAX;
            end else begin
                point_sat = mag_sum[POINT_W-1:0];
            end
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // sequencer, datapath and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            variant_reg <= dbp3_pkg::VARIANT_ORIG;
            coord_y_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            inv_fx_reg  <= dbp3_pkg::INV_FOCAL_X_RST;
            inv_fy_reg  <= dbp3_pkg::INV_FOCAL_Y_RST;
            cx_reg      <= dbp3_pkg::CENTER_X_RST;
            cy_reg      <= dbp3_pkg::CENTER_Y_RST;
            width_reg   <= dbp3_pkg::IMAGE_WIDTH_RST;
            height_reg  <= dbp3_pkg::IMAGE_HEIGHT_RST;
        end else begin
            // configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    dbp3_pkg::REG_INV_FOCAL_X:  inv_fx_reg <= cfg_data[INV_W-1:0];
                    dbp3_pkg::REG_INV_FOCAL_Y:  inv_fy_reg <= cfg_data[INV_W-1:0];
                    dbp3_pkg::REG_CENTER_X:     cx_reg     <= cfg_data[CENTER_W-1:0];
                    dbp3_pkg::REG_CENTER_Y:     cy_reg     <= cfg_data[CENTER_W-1:0];
                    dbp3_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                    dbp3_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            // output register drains, the emit step reloads it on its own
            if (m_valid_reg && m_tready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        col_reg     <= col_next;
                        row_reg     <= row_next;
                        depth_reg   <= s_tdata[DEPTH_W-1:0];
                        nx_reg      <= s_tdata[DEPTH_W +: NORM_W];
                        ny_reg      <= s_tdata[DEPTH_W + NORM_W +: NORM_W];
                        nz_reg      <= s_tdata[DEPTH_W + 2 * NORM_W +: NORM_W];
                        col_pos_reg <= $signed(PW'(cur_col));
                        row_pos_reg <= $signed(PW'(cur_row));
                        col_mir_reg <= col_mir;
                        row_mir_reg <= row_mir;
                        variant_reg <= dbp3_pkg::VARIANT_ORIG;
                        coord_y_reg <= 1'b0;
                        if (s_tdata[DEPTH_W-1:0] != '0) begin
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP: begin
                    neg_reg   <= offset[DW-1];
                    mag_reg   <= offset[DW-1] ? DW'(-offset) : DW'(offset);
                    state_reg <= ST_MUL_INV;
                end
                ST_MUL_INV: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO: begin
                    hi_reg    <= prod_reg[FRAC_W +: DW];
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    frac_reg  <= lo_round[LOW:FRAC_W];
                    prod_reg  <= mul_p;
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (coord_y_reg) begin
                        y_res_reg <= point_sat;
                        state_reg <= ST_EMIT;
                    end else begin
                        x_res_reg   <= point_sat;
                        coord_y_reg <= 1'b1;
                        state_reg   <= ST_SETUP;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        out_x_reg    <= x_res_reg;
                        out_y_reg    <= y_res_reg;
                        out_z_reg    <= depth_reg;
                        out_nx_reg   <= (variant_reg == dbp3_pkg::VARIANT_MIRROR_LR) ?
                                        dbp3_pkg::neg_norm(nx_reg) : nx_reg;
                        out_ny_reg   <= (variant_reg == dbp3_pkg::VARIANT_MIRROR_UD) ?
                                        dbp3_pkg::neg_norm(ny_reg) : ny_reg;
                        out_nz_reg   <= nz_reg;
                        out_var_reg  <= variant_reg;
                        out_last_reg <= (variant_reg == dbp3_pkg::VARIANT_MIRROR_UD);
                        coord_y_reg  <= 1'b0;
                        if (variant_reg == dbp3_pkg::VARIANT_MIRROR_UD) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            variant_reg <= variant_reg + dbp3_pkg::VARIANT_W'(1);
                            state_reg   <= ST_SETUP;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_nz_reg, out_ny_reg, out_nx_reg, out_z_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_var_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> tb/sv/depth_backprojection_flip3_tb.sv
// depth_backprojection_flip3_tb: self-checking bench for the depth back-projection block
// predicts the three points of every pixel of nonzero depth, checks them in order on the stream output
// depends on rtl/dbp3_pkg.sv and rtl/depth_backprojection_flip3.sv

module depth_backprojection_flip3_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbp3_pkg::*;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    // run limit covering all pixels and output stalls, with wide margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 500;

    typedef struct packed {
        logic [VARIANT_W-1:0] variant;
        logic [POINT_W-1:0]   px;
        logic [POINT_W-1:0]   py;
        logic [DEPTH_W-1:0]   pz;
        logic [NORM_W-1:0]    nx;
        logic [NORM_W-1:0]    ny;
        logic [NORM_W-1:0]    nz;
        logic                 last;
    } point_t;

    // camera model, pixel counters and the points still owed by the block
    class backproj_scoreboard;
        logic [INV_W-1:0]    inv_x, inv_y;
        logic [CENTER_W-1:0] cx, cy;
        logic [SIZE_W-1:0]   width_reg, height_reg;
        int                  col, row;
        point_t              awaited[$];
        int                  failures;

        function new();
            inv_x = INV_FOCAL_X_RST;
            inv_y = INV_FOCAL_Y_RST;
            cx = CENTER_X_RST;
            cy = CENTER_Y_RST;
            width_reg = IMAGE_WIDTH_RST;
            height_reg = IMAGE_HEIGHT_RST;
            col = 0;
            row = 0;
            failures = 0;
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_INV_FOCAL_X: inv_x = value[INV_W-1:0];
                REG_INV_FOCAL_Y: inv_y = value[INV_W-1:0];
                REG_CENTER_X: cx = value[CENTER_W-1:0];
                REG_CENTER_Y: cy = value[CENTER_W-1:0];
                REG_IMAGE_WIDTH: width_reg = value[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = value[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // zero counts as one, anything past the limit counts as the limit
        function int effective_size(logic [SIZE_W-1:0] v, int maxv);
            if (v == 0) return 1;
            if (int'(v) > maxv) return maxv;
            return int'(v);
        endfunction

        // (pos - center) * inv * depth in Q.8, rounded half away from zero, saturated
        function logic [POINT_W-1:0] project_mm(longint pos, logic [CENTER_W-1:0] center,
                                                logic [INV_W-1:0] inv, logic [DEPTH_W-1:0] depth);
            longint d;
            bit neg;
            longint unsigned mag, prod, hi, lo, r;
            logic [63:0] flipped;
            d = pos * 256 - longint'({44'd0, center});
            neg = d < 0;
            mag = neg ? longint'(-d) : longint'(d);
            prod = mag * {40'd0, inv};
            hi = prod >> 24;
            lo = prod & 64'hFF_FFFF;
            r = hi * {48'd0, depth} + ((lo * {48'd0, depth} + 64'h80_0000) >> 24);
            if (!neg) begin
                if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
                return r[POINT_W-1:0];
            end
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            flipped = ~r + 64'd1;
            return flipped[POINT_W-1:0];
        endfunction

        // mirrored normal component, the most negative code clips to the top
        function logic [NORM_W-1:0] flip_norm(logic [NORM_W-1:0] v);
            if (v == 16'h8000) return 16'h7FFF;
            return -v;
        endfunction

        function void note_pixel(bit frame_start, logic [DEPTH_W-1:0] depth,
                                 logic [NORM_W-1:0] nx, logic [NORM_W-1:0] ny,
                                 logic [NORM_W-1:0] nz);
            int w, h;
            longint cols[3], rows[3];
            logic [VARIANT_W-1:0] kinds[3];
            point_t p;
            w = effective_size(width_reg, MAX_WIDTH_DEF);
            h = effective_size(height_reg, MAX_HEIGHT_DEF);
            kinds = '{VARIANT_ORIG, VARIANT_MIRROR_LR, VARIANT_MIRROR_UD};
            if (frame_start) begin
                col = 0;
                row = 0;
            end
            // mirrored positions can go negative when the counters run past the frame
            cols = '{longint'(col), longint'(w) - 1 - col, longint'(col)};
            rows = '{longint'(row), longint'(row), longint'(h) - 1 - row};
            if (depth != 0) begin
                for (int k = 0; k < 3; k++) begin
                    p.variant = kinds[k];
                    p.px = project_mm(cols[k], cx, inv_x, depth);
                    p.py = project_mm(rows[k], cy, inv_y, depth);
                    p.pz = depth;
                    p.nx = (kinds[k] == VARIANT_MIRROR_LR) ? flip_norm(nx) : nx;
                    p.ny = (kinds[k] == VARIANT_MIRROR_UD) ? flip_norm(ny) : ny;
                    p.nz = nz;
                    p.last = (kinds[k] == VARIANT_MIRROR_UD);
                    awaited = {awaited, p};
                end
            end
            // raster advance, rows roll over at the height limit
            if (col + 1 >= w) begin
                col = 0;
                row++;
                if (row >= MAX_HEIGHT_DEF) row = 0;
            end else begin
                col++;
            end
        endfunction

        function void match(string field, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_point(logic [VARIANT_W-1:0] variant, logic [M_TDATA_W-1:0] data,
                                  logic last);
            point_t want;
            if (awaited.size() == 0) begin
                $error("point item with no expected point, variant %0d", variant);
                failures++;
                return;
            end
            want = awaited.pop_front();
            match("variant", want.variant, variant);
            match("point_x", longint'($signed(want.px)), longint'($signed(data[31:0])));
            match("point_y", longint'($signed(want.py)), longint'($signed(data[63:32])));
            match("point_z", want.pz, data[79:64]);
            match("norm_x_out", longint'($signed(want.nx)), longint'($signed(data[95:80])));
            match("norm_y_out", longint'($signed(want.ny)), longint'($signed(data[111:96])));
            match("norm_z_out", longint'($signed(want.nz)), longint'($signed(data[127:112])));
            match("last", want.last, last);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_INV_FOCAL_X;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata: depth_mm, norm_x_in, norm_y_in, norm_z_in
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // s_tuser: frame_start
    logic [0:0]             s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata: point_x, point_y, point_z, norm_x_out, norm_y_out, norm_z_out
    logic [M_TDATA_W-1:0]   m_tdata;
    // m_tuser: variant
    logic [VARIANT_W-1:0]   m_tuser;
    logic                   m_tlast;

    backproj_scoreboard sb;
    int idle_pct = 25;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int cycles = 0;

    depth_backprojection_flip3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // point receiver: check accepted items, random backpressure, long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_point(m_tuser, m_tdata, m_tlast);
        end
        if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // offer one pixel until taken, then maybe leave a short random idle gap
    task automatic send_pixel(input bit frame_start, input logic [DEPTH_W-1:0] depth,
                              input logic [NORM_W-1:0] nx, input logic [NORM_W-1:0] ny,
                              input logic [NORM_W-1:0] nz);
        s_tvalid <= 1'b1;
        s_tuser <= frame_start;
        s_tdata <= {nz, ny, nx, depth};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(frame_start, depth, nx, ny, nz);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // drain every owed point, then give the block time to settle
    task automatic settle();
        if (s_tvalid) s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all six camera registers back to back, optionally poke the unused indexes
    task automatic program_camera(input logic [CFG_DATA_W-1:0] ifx, input logic [CFG_DATA_W-1:0] ify,
                                  input logic [CFG_DATA_W-1:0] ccx, input logic [CFG_DATA_W-1:0] ccy,
                                  input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                                  input bit spare);
        logic [CFG_INDEX_W-1:0] idx[8];
        logic [CFG_DATA_W-1:0]  vals[8];
        idx = '{REG_INV_FOCAL_X, REG_INV_FOCAL_Y, REG_CENTER_X, REG_CENTER_Y,
                REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_SPARE_A, REG_SPARE_B};
        vals = '{ifx, ify, ccx, ccy, w, h, 24'hFFFFFF, 24'h000001};
        for (int i = 0; i < (spare ? 8 : 6); i++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge aclk);
            sb.note_config(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // random camera, mostly tiny frames so wraps and mirrors show up often
    task automatic random_camera();
        int w, h;
        logic [CFG_DATA_W-1:0] ifx, ify, ccx, ccy;
        w = ($urandom_range(9) == 0) ? $urandom_range(17, 8191) : $urandom_range(1, 16);
        h = ($urandom_range(9) == 0) ? $urandom_range(17, 8191) : $urandom_range(1, 16);
        ifx = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(8000, 300000));
        ify = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(8000, 300000));
        ccx = ($urandom_range(3) == 0) ? 24'($urandom_range(0, 20'hFFFFF))
                                       : 24'(20'(w * 128 + $urandom_range(0, 255)));
        ccy = ($urandom_range(3) == 0) ? 24'($urandom_range(0, 20'hFFFFF))
                                       : 24'(20'(h * 128 + $urandom_range(0, 255)));
        program_camera(ifx, ify, ccx, ccy, 24'(w), 24'(h), 1'b0);
    endtask

    function automatic logic [NORM_W-1:0] random_norm();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // frames in raster order with random content, a rare frame restart and some gaps
    task automatic random_frames(input int count);
        for (int i = 0; i < count; i++) begin
            bit fs;
            int pick;
            logic [DEPTH_W-1:0] depth;
            fs = (i == 0) || ($urandom_range(99) < 4);
            pick = $urandom_range(99);
            depth = (pick < 15) ? 16'd0 : (pick < 20) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            send_pixel(fs, depth, random_norm(), random_norm(), random_norm());
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset camera: depth and normal extremes, zero depth, restart mid-frame
        send_pixel(1'b1, 16'd1, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(1'b0, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
        send_pixel(1'b0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_pixel(1'b0, 16'd1000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_pixel(1'b0, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF);
        send_pixel(1'b1, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h0001);
        send_pixel(1'b0, 16'd1234, 16'hFFFF, 16'h0001, 16'h0000);
        settle();

        // largest focal reciprocals and frame, centers at both ends: saturation both ways
        program_camera(24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'hFFFFF, 24'd4096, 24'd4096, 1'b1);
        send_pixel(1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h1234);
        send_pixel(1'b0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_pixel(1'b0, 16'd0, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(1'b0, 16'd1, 16'h0001, 16'hFFFF, 16'h7FFF);
        settle();

        // zero focal reciprocals, size registers zero once masked to their width
        program_camera(24'h0, 24'h0, 24'hFFFFF, 24'hFFFFF, 24'h002000, 24'h0, 1'b0);
        send_pixel(1'b0, 16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF);
        send_pixel(1'b0, 16'd77, 16'h0100, 16'hFF00, 16'h00FF);
        send_pixel(1'b1, 16'd3, 16'h4000, 16'hC000, 16'h8001);
        settle();

        // sizes beyond the frame limit
        program_camera(24'd40000, 24'd52000, 24'd300000, 24'd200000, 24'd8191, 24'd8191, 1'b1);
        send_pixel(1'b1, 16'd2500, 16'h1111, 16'h2222, 16'h3333);
        send_pixel(1'b0, 16'd60000, 16'hEEEE, 16'hDDDD, 16'hCCCC);
        send_pixel(1'b0, 16'd9, 16'h8000, 16'h7FFF, 16'h0000);
        settle();

        // one-pixel rows: run the row counter past the frame height with zero-depth pixels
        program_camera(24'd30000, 24'd30000, 24'd100, 24'd500, 24'd1, 24'd3, 1'b0);
        send_pixel(1'b1, 16'd0, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 1; i < 8; i++) begin
            send_pixel(1'b0, 16'd0, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        for (int i = 0; i < 4; i++) begin
            send_pixel(1'b0, 16'($urandom_range(1, 65535)), random_norm(), random_norm(),
                       random_norm());
        end
        settle();

        // random cameras and frames; one phase without gaps, one with a long output hold
        for (int phase = 0; phase < 6; phase++) begin
            random_camera();
            idle_pct = (phase == 2) ? 0 : 25;
            if (phase == 4) holds_asked++;
            random_frames(17);
            settle();
        end

        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> depth_backprojection_flip3.f
rtl/dbp3_pkg.sv
rtl/depth_backprojection_flip3.sv
tb/sv/depth_backprojection_flip3_tb.sv
